>>> src/assert_macros.svh
// Assertion macros for the tag/policy block RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(expr), msg)

`endif

>>> src/scatp_pkg.sv
// Shared types and constants of the set-associative tag/policy block.
// Depends on nothing; imported by every module of the block but scatp_ram.
`default_nettype none

package scatp_pkg;

   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int SET_OUT_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int WAYS_CNT_W = 5;

   typedef enum logic [1:0] {
      POL_LRU  = 2'd0,
      POL_FIFO = 2'd1,
      POL_LIFO = 2'd2
   } policy_type;

   typedef enum logic [1:0] {
      CLS_HIT        = 2'd0,
      CLS_COMPULSORY = 2'd1,
      CLS_CONFLICT   = 2'd2,
      CLS_CAPACITY   = 2'd3
   } miss_class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY      = 2'd0,
      CSR_OFFSET_BITS = 2'd1,
      CSR_INDEX_BITS  = 2'd2,
      CSR_WAYS_IN_USE = 2'd3
   } csr_index_type;

   typedef struct packed {
      policy_type            policy;
      logic [3:0]            offset_bits;
      logic [2:0]            index_bits;
      logic [WAYS_CNT_W-1:0] ways;
   } geom_type;

   typedef struct packed {
      logic           hit;
      miss_class_type miss_class;
      logic           became_full;
   } upd_status_type;

endpackage

`default_nettype wire

>>> src/set_assoc_cache_tag_policy.sv
// Set-associative cache tag lookup with LRU, FIFO or LIFO replacement.
// One access is taken every clock (busy never rises). Its result passes
// through the registered read of the set's tag row and then the compare
// and update, whose result is registered onto the rsp_ ports, where it is
// strobed for a single cycle. The receiver cannot stall results. Consecutive
// accesses to the same set are forwarded around the tag RAM. Writing
// offset_bits, index_bits or ways_in_use empties every set at once; the
// hit and miss totals are kept and saturate at all ones.
// Depends on scatp_pkg, scatp_ram, scatp_split, scatp_update, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_tag_policy import scatp_pkg::*; #(
   parameter int SETS         = 64,
   parameter int WAYS         = 4,
   parameter int ADDRESS_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  req_is_write,
   output logic                       rsp_strobe,
   output logic                       rsp_hit,
   output logic [1:0]                 rsp_miss_class,
   output logic [SET_OUT_W-1:0]       rsp_set_number,
   output logic [COUNT_W-1:0]         rsp_total_hits,
   output logic [COUNT_W-1:0]         rsp_total_misses,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW      = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int IDX_MAX = $clog2(SETS + 1) - 1;
   localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W  = $clog2(WAYS + 1);
   localparam int FCW     = $clog2(SETS + 1);
   localparam int ROW_W   = FILL_W + WAYS * RANK_W + WAYS * AW;

   policy_type         policy_ff, policy_in;
   logic [3:0]         offset_ff, offset_in;
   logic [2:0]         index_ff, index_in;
   logic [2:0]         ways_ff, ways_in;
   logic               flush;
   geom_type           geom;

   logic               accept;
   logic [SET_W-1:0]   set0;
   logic [AW-1:0]      tag0;

   logic               s1_valid_ff, s1_valid_in;
   logic [SET_W-1:0]   s1_set_ff, s1_set_in;
   logic [AW-1:0]      s1_tag_ff, s1_tag_in;

   logic               last_valid_ff, last_valid_in;
   logic [SET_W-1:0]   last_set_ff, last_set_in;
   logic [ROW_W-1:0]   last_row_ff, last_row_in;

   logic [SETS-1:0]    set_valid_ff, set_valid_in;
   logic [FCW-1:0]     full_count_ff, full_count_in;
   logic [FCW-1:0]     sets_used;
   logic               all_full;

   logic [COUNT_W-1:0] hits_ff, hits_in;
   logic [COUNT_W-1:0] misses_ff, misses_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_hit_ff, rsp_hit_in;
   miss_class_type     rsp_class_ff, rsp_class_in;
   logic [SET_OUT_W-1:0] rsp_set_ff, rsp_set_in;
   logic [SET_W+SET_OUT_W-1:0] set_wide;

   logic [ROW_W-1:0]   ram_rdata;
   logic [ROW_W-1:0]   row;
   logic [ROW_W-1:0]   new_row;
   logic [FILL_W-1:0]  rd_fill;
   logic [FILL_W-1:0]  wr_fill;
   logic [WAYS*RANK_W-1:0] wr_ranks;
   logic [WAYS*AW-1:0] wr_tags;
   upd_status_type     status;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign geom.policy      = policy_ff;
   assign geom.offset_bits = offset_ff;
   assign geom.index_bits  = (int'(index_ff) > IDX_MAX) ? 3'(IDX_MAX) : index_ff;
   assign geom.ways        = (ways_ff == 3'd0) ? WAYS_CNT_W'(1) :
                             (int'(ways_ff) > WAYS) ? WAYS_CNT_W'(WAYS) :
                             WAYS_CNT_W'(ways_ff);

   assign sets_used = FCW'(1) << geom.index_bits;
   assign all_full  = full_count_ff >= sets_used;

   scatp_split #(
      .AW    (AW),
      .SET_W (SET_W)
   ) u_split (
      .address     (req_address),
      .offset_bits (geom.offset_bits),
      .index_bits  (geom.index_bits),
      .set_index   (set0),
      .tag         (tag0)
   );

   scatp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_set_ff),
      .wdata (new_row),
      .raddr (set0),
      .rdata (ram_rdata)
   );

   assign row     = (last_valid_ff && (last_set_ff == s1_set_ff)) ? last_row_ff : ram_rdata;
   assign rd_fill = set_valid_ff[s1_set_ff] ? row[ROW_W-1 -: FILL_W] : '0;
   assign new_row = {wr_fill, wr_ranks, wr_tags};

   scatp_update #(
      .WAYS   (WAYS),
      .TAG_W  (AW),
      .RANK_W (RANK_W),
      .FILL_W (FILL_W)
   ) u_update (
      .geom     (geom),
      .tag      (s1_tag_ff),
      .all_full (all_full),
      .rd_fill  (rd_fill),
      .rd_ranks (row[WAYS*AW +: WAYS*RANK_W]),
      .rd_tags  (row[WAYS*AW-1:0]),
      .wr_fill  (wr_fill),
      .wr_ranks (wr_ranks),
      .wr_tags  (wr_tags),
      .status   (status)
   );

   assign set_wide = {{SET_OUT_W{1'b0}}, s1_set_ff};

   always_comb begin
      policy_in = policy_ff;
      offset_in = offset_ff;
      index_in  = index_ff;
      ways_in   = ways_ff;
      flush     = 1'b0;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POLICY: begin
               policy_in = policy_type'(csr_wdata[1:0]);
            end
            CSR_OFFSET_BITS: begin
               offset_in = csr_wdata[3:0];
               flush     = 1'b1;
            end
            CSR_INDEX_BITS: begin
               index_in = csr_wdata[2:0];
               flush    = 1'b1;
            end
            CSR_WAYS_IN_USE: begin
               ways_in = csr_wdata[2:0];
               flush   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = accept;
      s1_set_in   = set0;
      s1_tag_in   = tag0;

      last_valid_in = s1_valid_ff && !flush;
      last_set_in   = s1_set_ff;
      last_row_in   = new_row;

      set_valid_in  = set_valid_ff;
      full_count_in = full_count_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      if (s1_valid_ff) begin
         set_valid_in[s1_set_ff] = 1'b1;
         if (status.became_full) begin
            full_count_in = full_count_ff + FCW'(1);
         end
         if (status.hit) begin
            if (hits_ff != '1) begin
               hits_in = hits_ff + COUNT_W'(1);
            end
         end else if (misses_ff != '1) begin
            misses_in = misses_ff + COUNT_W'(1);
         end
      end
      if (flush) begin
         set_valid_in  = '0;
         full_count_in = '0;
      end

      rsp_strobe_in = s1_valid_ff;
      rsp_hit_in    = status.hit;
      rsp_class_in  = status.miss_class;
      rsp_set_in    = set_wide[SET_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POL_LRU;
         offset_ff     <= 4'd4;
         index_ff      <= 3'd6;
         ways_ff       <= 3'd4;
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
         set_valid_ff  <= '0;
         full_count_ff <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         policy_ff     <= policy_in;
         offset_ff     <= offset_in;
         index_ff      <= index_in;
         ways_ff       <= ways_in;
         s1_valid_ff   <= s1_valid_in;
         last_valid_ff <= last_valid_in;
         set_valid_ff  <= set_valid_in;
         full_count_ff <= full_count_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      s1_set_ff    <= s1_set_in;
      s1_tag_ff    <= s1_tag_in;
      last_set_ff  <= last_set_in;
      last_row_ff  <= last_row_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_class_ff <= rsp_class_in;
      rsp_set_ff   <= rsp_set_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_miss_class   = rsp_class_ff;
   assign rsp_set_number   = rsp_set_ff;
   assign rsp_total_hits   = hits_ff;
   assign rsp_total_misses = misses_ff;

   `ASSERT_PROP(a_result_follows_accept, clock, reset, accept |-> ##2 rsp_strobe, "transaction lost")
   `ASSERT_PROP(a_hit_class_agree, clock, reset, rsp_strobe |-> (rsp_hit == (rsp_class_ff == CLS_HIT)), "hit flag and class disagree")
   `ASSERT_PROP(a_totals_hold_when_idle, clock, reset, !s1_valid_ff |=> $stable(hits_ff) && $stable(misses_ff), "totals moved without a transaction")
   `ASSERT_NEVER(a_full_count_bound, clock, reset, full_count_ff > FCW'(SETS), "full set count exceeds set count")

endmodule

`default_nettype wire

>>> src/scatp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the per-set tag rows.
`default_nettype none

module scatp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [WIDTH-1:0] rdata_in;

   assign rdata_in = mem[raddr];
   assign rdata    = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= rdata_in;
   end

endmodule

`default_nettype wire

>>> src/scatp_split.sv
// Address split into set index and tag by the configured bit counts.
// Depends on scatp_pkg.
`default_nettype none

module scatp_split import scatp_pkg::*; #(
   parameter int AW    = 32,
   parameter int SET_W = 6
) (
   input  wire logic [ADDR_W-1:0] address,
   input  wire logic [3:0]        offset_bits,
   input  wire logic [2:0]        index_bits,
   output logic [SET_W-1:0]       set_index,
   output logic [AW-1:0]          tag
);

   logic [AW-1:0]       addr;
   logic [AW+SET_W-1:0] sh_wide;
   logic [SET_W-1:0]    set_mask;
   logic [4:0]          tag_shift;

   assign addr      = address[AW-1:0];
   assign sh_wide   = {{SET_W{1'b0}}, addr} >> offset_bits;
   assign tag_shift = 5'(offset_bits) + 5'(index_bits);
   assign tag       = addr >> tag_shift;
   assign set_index = sh_wide[SET_W-1:0] & set_mask;

   always_comb begin
      for (int b = 0; b < SET_W; b++) begin
         set_mask[b] = (b < int'(index_bits));
      end
   end

endmodule

`default_nettype wire

>>> src/scatp_update.sv
// Per-set lookup and replacement: tag compare, hit/miss class, new row.
// Depends on scatp_pkg.
`default_nettype none

module scatp_update import scatp_pkg::*; #(
   parameter int WAYS   = 4,
   parameter int TAG_W  = 32,
   parameter int RANK_W = 2,
   parameter int FILL_W = 3
) (
   input  wire geom_type                 geom,
   input  wire logic [TAG_W-1:0]         tag,
   input  wire logic                     all_full,
   input  wire logic [FILL_W-1:0]        rd_fill,
   input  wire logic [WAYS*RANK_W-1:0]   rd_ranks,
   input  wire logic [WAYS*TAG_W-1:0]    rd_tags,
   output logic [FILL_W-1:0]             wr_fill,
   output logic [WAYS*RANK_W-1:0]        wr_ranks,
   output logic [WAYS*TAG_W-1:0]         wr_tags,
   output upd_status_type                status
);

   logic [WAYS_CNT_W-1:0] fill_c;
   logic [WAYS_CNT_W-1:0] fill_m1;
   logic [WAYS-1:0]       in_use;
   logic [WAYS-1:0]       match;
   logic                  hit;
   logic                  evict_oldest;
   logic [RANK_W-1:0]     hit_way;
   logic [RANK_W-1:0]     hit_rank;
   logic [RANK_W-1:0]     victim;

   assign fill_c  = (WAYS_CNT_W'(rd_fill) > geom.ways) ? geom.ways : WAYS_CNT_W'(rd_fill);
   assign fill_m1 = fill_c - WAYS_CNT_W'(1);
   assign hit     = |match;

   always_comb begin
      case (geom.policy)
         POL_LRU, POL_FIFO: evict_oldest = 1'b1;
         default:           evict_oldest = 1'b0;
      endcase
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         in_use[w] = WAYS_CNT_W'(w) < fill_c;
         match[w]  = in_use[w] && (rd_tags[w*TAG_W +: TAG_W] == tag);
      end
   end

   always_comb begin
      hit_way  = '0;
      hit_rank = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way  = RANK_W'(w);
            hit_rank = rd_ranks[w*RANK_W +: RANK_W];
         end
      end
   end

   always_comb begin
      victim = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (in_use[w]) begin
            if (evict_oldest) begin
               if (rd_ranks[w*RANK_W +: RANK_W] == '0) begin
                  victim = RANK_W'(w);
               end
            end else if (rd_ranks[w*RANK_W +: RANK_W] == RANK_W'(fill_m1)) begin
               victim = RANK_W'(w);
            end
         end
      end
   end

   always_comb begin
      wr_tags            = rd_tags;
      wr_ranks           = rd_ranks;
      wr_fill            = FILL_W'(fill_c);
      status.hit         = hit;
      status.miss_class  = CLS_HIT;
      status.became_full = 1'b0;
      if (hit) begin
         if (geom.policy == POL_LRU) begin
            for (int w = 0; w < WAYS; w++) begin
               if (in_use[w]) begin
                  if (RANK_W'(w) == hit_way) begin
                     wr_ranks[w*RANK_W +: RANK_W] = RANK_W'(fill_m1);
                  end else if (rd_ranks[w*RANK_W +: RANK_W] > hit_rank) begin
                     wr_ranks[w*RANK_W +: RANK_W] = rd_ranks[w*RANK_W +: RANK_W] - 1'b1;
                  end
               end
            end
         end
      end else if (fill_c < geom.ways) begin
         status.miss_class  = CLS_COMPULSORY;
         status.became_full = (fill_c + WAYS_CNT_W'(1)) == geom.ways;
         wr_fill            = FILL_W'(fill_c + WAYS_CNT_W'(1));
         for (int w = 0; w < WAYS; w++) begin
            if (WAYS_CNT_W'(w) == fill_c) begin
               wr_tags[w*TAG_W +: TAG_W]    = tag;
               wr_ranks[w*RANK_W +: RANK_W] = RANK_W'(fill_c);
            end
         end
      end else begin
         status.miss_class = all_full ? CLS_CAPACITY : CLS_CONFLICT;
         for (int w = 0; w < WAYS; w++) begin
            if (RANK_W'(w) == victim) begin
               wr_tags[w*TAG_W +: TAG_W]    = tag;
               wr_ranks[w*RANK_W +: RANK_W] = RANK_W'(fill_m1);
            end else if (evict_oldest && in_use[w]
                         && (rd_ranks[w*RANK_W +: RANK_W] != '0)) begin
               wr_ranks[w*RANK_W +: RANK_W] = rd_ranks[w*RANK_W +: RANK_W] - 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for set_assoc_cache_tag_policy: directed and random accesses,
// checked against a tag/replacement predictor kept in this file or, for the first
// directed accesses, against results given in the plan. Depends on scatp_pkg and the set_assoc_cache_tag_policy RTL.

module testbench;
   import scatp_pkg::*;

   localparam int NUM_SETS       = 64;
   localparam int NUM_WAYS       = 4;
   localparam int PHASES         = 15;
   localparam int PHASE_ITEMS    = 100;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic                 hit;
      logic [1:0]           cls;
      logic [SET_OUT_W-1:0] set_no;
      logic [COUNT_W-1:0]   hits;
      logic [COUNT_W-1:0]   misses;
   } lookup_type;

   typedef struct {
      bit                    is_reg;
      csr_index_type         sel;
      logic [CSR_DATA_W-1:0] wdata;
      logic [ADDR_W-1:0]     addr;
      logic                  wr;
      bit                    typed;
      lookup_type            want;
   } step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  req_is_write = 1'b0;
   logic                  rsp_strobe;
   logic                  rsp_hit;
   logic [1:0]            rsp_miss_class;
   logic [SET_OUT_W-1:0]  rsp_set_number;
   logic [COUNT_W-1:0]    rsp_total_hits;
   logic [COUNT_W-1:0]    rsp_total_misses;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_POLICY;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   set_assoc_cache_tag_policy dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_address      (req_address),
      .req_is_write     (req_is_write),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_miss_class   (rsp_miss_class),
      .rsp_set_number   (rsp_set_number),
      .rsp_total_hits   (rsp_total_hits),
      .rsp_total_misses (rsp_total_misses),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [1:0]        cfg_policy = POL_LRU;
   logic [3:0]        cfg_offset = 4'd4;
   logic [2:0]        cfg_index  = 3'd6;
   logic [2:0]        cfg_ways   = 3'd4;
   logic [ADDR_W-1:0] tag_mem  [NUM_SETS][NUM_WAYS];
   int                rank_mem [NUM_SETS][NUM_WAYS];
   int                fill_cnt [NUM_SETS];
   int                full_sets;
   logic [COUNT_W-1:0] hits_total   = '0;
   logic [COUNT_W-1:0] misses_total = '0;

   lookup_type        expected_lookups [$];
   bit                drive_typed = 1'b0;
   lookup_type        drive_want = '0;
   bit                take_now = 1'b0;
   bit                take_typed = 1'b0;
   lookup_type        take_want = '0;
   logic [ADDR_W-1:0] take_addr = '0;
   int                idle_cycles = 0;
   int                mismatches = 0;

   step_type plan [] = '{
      '{0, CSR_POLICY, 4'h0, 32'h0000_0000, 1'b0, 1, '{1'b0, CLS_COMPULSORY, 6'd0, 32'd0, 32'd1}},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0000, 1'b1, 1, '{1'b1, CLS_HIT, 6'd0, 32'd1, 32'd1}},
      '{0, CSR_POLICY, 4'h0, 32'hFFFF_FFFF, 1'b0, 1, '{1'b0, CLS_COMPULSORY, 6'd63, 32'd1, 32'd2}},
      '{0, CSR_POLICY, 4'h0, 32'hFFFF_FFF0, 1'b1, 1, '{1'b1, CLS_HIT, 6'd63, 32'd2, 32'd2}},
      '{0, CSR_POLICY, 4'h0, 32'h0000_000F, 1'b0, 1, '{1'b1, CLS_HIT, 6'd0, 32'd3, 32'd2}},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0400, 1'b1, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0800, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0C00, 1'b1, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0400, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_1000, 1'b1, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0000, 1'b0, 0, '0},
      '{1, CSR_POLICY, 4'hD, 32'h0000_0000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0800, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_2000, 1'b1, 0, '0},
      '{1, CSR_POLICY, 4'hB, 32'h0000_0000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_3000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_3000, 1'b1, 0, '0},
      '{1, CSR_OFFSET_BITS, 4'h0, 32'h0000_0000, 1'b0, 0, '0},
      '{1, CSR_INDEX_BITS, 4'hF, 32'h0000_0000, 1'b0, 0, '0},
      '{1, CSR_WAYS_IN_USE, 4'h0, 32'h0000_0000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_0040, 1'b1, 0, '0},
      '{1, CSR_INDEX_BITS, 4'h8, 32'h0000_0000, 1'b0, 0, '0},
      '{1, CSR_WAYS_IN_USE, 4'hF, 32'h0000_0000, 1'b0, 0, '0},
      '{1, CSR_OFFSET_BITS, 4'hF, 32'h0000_0000, 1'b0, 0, '0},
      '{1, CSR_POLICY, 4'h6, 32'h0000_0000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'hFFFF_FFFF, 1'b1, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0000_8000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0001_0000, 1'b1, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0001_8000, 1'b0, 0, '0},
      '{0, CSR_POLICY, 4'h0, 32'h0002_0000, 1'b1, 0, '0}
   };

   function automatic int index_width();
      int k;
      k = 0;
      while (k < cfg_index && (2 << k) <= NUM_SETS) k++;
      return k;
   endfunction

   function automatic int way_limit();
      int w;
      w = cfg_ways;
      if (w < 1) w = 1;
      if (w > NUM_WAYS) w = NUM_WAYS;
      return w;
   endfunction

   function automatic void empty_sets();
      for (int s = 0; s < NUM_SETS; s++) begin
         fill_cnt[s] = 0;
         for (int w = 0; w < NUM_WAYS; w++) rank_mem[s][w] = 0;
      end
      full_sets = 0;
   endfunction

   function automatic void enqueue_lookup(lookup_type item);
      expected_lookups.insert(expected_lookups.size(), item);
   endfunction

   function automatic void apply_reg(csr_index_type sel, logic [CSR_DATA_W-1:0] d);
      case (sel)
         CSR_POLICY: begin
            cfg_policy = d[1:0];
         end
         CSR_OFFSET_BITS: begin
            cfg_offset = d;
            empty_sets();
         end
         CSR_INDEX_BITS: begin
            cfg_index = d[2:0];
            empty_sets();
         end
         CSR_WAYS_IN_USE: begin
            cfg_ways = d[2:0];
            empty_sets();
         end
         default: begin
         end
      endcase
   endfunction

   function automatic lookup_type lookup_and_update(logic [ADDR_W-1:0] addr);
      int k, ways, fill, hit_way, victim, set_i, r;
      logic [ADDR_W-1:0] tag;
      bit found;
      lookup_type res;
      k = index_width();
      set_i = int'((addr >> cfg_offset) & ((32'd1 << k) - 32'd1));
      tag = addr >> (cfg_offset + k);
      ways = way_limit();
      fill = fill_cnt[set_i];
      if (fill > ways) fill = ways;
      found = 1'b0;
      hit_way = 0;
      for (int w = 0; w < fill; w++) begin
         if (!found && tag_mem[set_i][w] == tag) begin
            found = 1'b1;
            hit_way = w;
         end
      end
      res.hit = found;
      res.set_no = set_i[SET_OUT_W-1:0];
      if (found) begin
         res.cls = CLS_HIT;
         if (hits_total != '1) hits_total++;
         if (cfg_policy == POL_LRU) begin
            r = rank_mem[set_i][hit_way];
            for (int w = 0; w < fill; w++)
               if (rank_mem[set_i][w] > r) rank_mem[set_i][w]--;
            rank_mem[set_i][hit_way] = fill - 1;
         end
      end else begin
         if (misses_total != '1) misses_total++;
         if (fill < ways) begin
            res.cls = CLS_COMPULSORY;
            tag_mem[set_i][fill] = tag;
            rank_mem[set_i][fill] = fill;
            fill_cnt[set_i] = fill + 1;
            if (fill + 1 == ways) full_sets++;
         end else begin
            victim = 0;
            if (cfg_policy == POL_LRU || cfg_policy == POL_FIFO) begin
               for (int w = 0; w < fill; w++)
                  if (rank_mem[set_i][w] == 0) victim = w;
               for (int w = 0; w < fill; w++)
                  if (w != victim && rank_mem[set_i][w] > 0) rank_mem[set_i][w]--;
            end else begin
               for (int w = 0; w < fill; w++)
                  if (rank_mem[set_i][w] == fill - 1) victim = w;
            end
            tag_mem[set_i][victim] = tag;
            rank_mem[set_i][victim] = fill - 1;
            res.cls = (full_sets >= (1 << k)) ? CLS_CAPACITY : CLS_CONFLICT;
         end
      end
      res.hits = hits_total;
      res.misses = misses_total;
      return res;
   endfunction

   task automatic report_mismatch(string what, lookup_type want, lookup_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected %0b/%0d/%0d/%0d/%0d, got %0b/%0d/%0d/%0d/%0d",
                  what, want.hit, want.cls, want.set_no, want.hits, want.misses,
                  got.hit, got.cls, got.set_no, got.hits, got.misses);
   endtask

   always @(negedge clock) begin
      lookup_type got;
      lookup_type want;
      got = {rsp_hit, rsp_miss_class, rsp_set_number, rsp_total_hits, rsp_total_misses};
      take_now = !reset && start === 1'b1 && busy === 1'b0;
      take_addr = req_address;
      take_typed = drive_typed;
      take_want = drive_want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch("unexpected transaction", '0, got);
         end else begin
            want = expected_lookups.pop_front();
            if (got.hit !== want.hit || got.cls !== want.cls || got.set_no !== want.set_no ||
                got.hits !== want.hits || got.misses !== want.misses)
               report_mismatch("mismatch", want, got);
         end
      end
      if (reset || take_now || rsp_strobe === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      lookup_type predicted;
      if (take_now) begin
         predicted = lookup_and_update(take_addr);
         enqueue_lookup(take_typed ? take_want : predicted);
      end
   end

   task automatic send_access(logic [ADDR_W-1:0] addr, logic wr, bit typed, lookup_type want);
      @(posedge clock);
      start <= 1'b1;
      req_address <= addr;
      req_is_write <= wr;
      drive_typed = typed;
      drive_want = want;
      do @(negedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(posedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain();
      @(posedge clock);
      start <= 1'b0;
      @(negedge clock);
      while (expected_lookups.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type sel, logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_reg(sel, d);
   endtask

   initial begin
      int k, ways, hot, span, set_base, set_i, burst;
      bit gapless, prev_reg;
      logic [ADDR_W-1:0] addr, tag_base, tag;
      logic [CSR_DATA_W-1:0] d [4];
      prev_reg = 1'b0;
      empty_sets();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!prev_reg) drain();
            write_reg(plan[i].sel, plan[i].wdata);
         end else begin
            send_access(plan[i].addr, plan[i].wr, plan[i].typed, plan[i].want);
         end
         prev_reg = plan[i].is_reg;
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         for (int r = 0; r < 4; r++) begin
            if (p == 0) d[r] = 4'h0;
            else if (p == 1) d[r] = 4'hF;
            else if (p == 2) d[r] = (r == 0) ? 4'h2 : 4'h4;
            else d[r] = CSR_DATA_W'($urandom_range(0, 15));
         end
         write_reg(CSR_POLICY, d[0]);
         write_reg(CSR_OFFSET_BITS, d[1]);
         write_reg(CSR_INDEX_BITS, d[2]);
         write_reg(CSR_WAYS_IN_USE, d[3]);

         k = index_width();
         ways = way_limit();
         hot = ((1 << k) > 8) ? $urandom_range(1, 4) : (1 << k);
         set_base = $urandom_range(0, NUM_SETS - 1);
         span = ways + $urandom_range(1, 3);
         tag_base = $urandom();
         gapless = ($urandom_range(0, 3) == 0);
         burst = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == PHASE_ITEMS / 2) drain();
            if (burst == 0) begin
               burst = $urandom_range(1, 24);
               if (!gapless) hold_off($urandom_range(1, 8));
            end
            burst--;
            if ($urandom_range(0, 99) < 15) begin
               addr = $urandom();
            end else begin
               set_i = (set_base + $urandom_range(0, hot - 1)) & ((1 << k) - 1);
               tag = tag_base + $urandom_range(0, span - 1);
               addr = (tag << (cfg_offset + k)) | (ADDR_W'(set_i) << cfg_offset) |
                      ($urandom() & ((32'd1 << cfg_offset) - 32'd1));
            end
            send_access(addr, 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
